>>> src/fsmc_pkg.sv
// ----------------------------------------------------------------------------
// fsmc_pkg
// shared types and constants of the same-length fir convolution block
// ----------------------------------------------------------------------------
package fsmc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 18;
  localparam int TAP_CNT_W = 3;
  localparam int NUM_COEF  = 7;
  localparam int SEEN_W    = 3;
  localparam int SEEN_MAX  = 7;
  localparam int D_W       = 2;
  localparam int HALF_MAX  = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int VAL_MAX   = 8388607;
  localparam int VAL_MIN   = -8388608;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_BASE = 3'd1;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 3'd1;
  localparam logic [COEF_W-1:0]    COEF_0_RESET    = 18'd65536;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       scan_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       run_last;
    logic                       bad_kernel;
  } out_word_t;

  typedef struct packed {
    logic [TAP_CNT_W-1:0]            tap_count;
    logic [NUM_COEF-1:0][COEF_W-1:0] coef;
  } cfg_t;

  typedef struct packed {
    logic run_last;
    logic bad_kernel;
  } job_ctl_t;

endpackage

>>> src/fsmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// fsmc_cfg_regs
// apb register file: tap count and kernel coefficients
// ----------------------------------------------------------------------------
module fsmc_cfg_regs import fsmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [TAP_CNT_W-1:0]            tap_count_r;
  logic [NUM_COEF-1:0][COEF_W-1:0] coef_r;
  logic [REG_IDX_W-1:0]            reg_idx;
  logic [REG_IDX_W-1:0]            coef_idx;
  logic                            wr_en;

  assign reg_idx  = cfg_paddr[APB_ADDR_W-1:2];
  assign coef_idx = reg_idx - REG_COEF_BASE;
  assign wr_en    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
      // tap 0 is unity, the rest are zero
      coef_r      <= {{((NUM_COEF-1)*COEF_W){1'b0}}, COEF_0_RESET};
    end else if (wr_en) begin
      if (reg_idx == REG_TAP_COUNT) begin
        tap_count_r <= cfg_pwdata[TAP_CNT_W-1:0];
      end else begin
        coef_r[coef_idx] <= cfg_pwdata[COEF_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_TAP_COUNT) begin
      cfg_prdata = {{(APB_DATA_W-TAP_CNT_W){1'b0}}, tap_count_r};
    end else begin
      cfg_prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_r[coef_idx]};
    end
  end

  assign cfg_pready    = 1'b1;
  assign cfg.tap_count = tap_count_r;
  assign cfg.coef      = coef_r;

endmodule

>>> src/fsmc_window.sv
// ----------------------------------------------------------------------------
// fsmc_window
// sample history and result sequencer: one window per result
// ----------------------------------------------------------------------------
module fsmc_window import fsmc_pkg::*; #(
  parameter int MAX_TAPS = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cfg_t                               cfg,
  input  logic                               in_valid,
  input  in_word_t                           in_data,
  output logic                               in_stall,
  input  logic                               job_adv,
  output logic                               job_valid,
  output job_ctl_t                           job_ctl,
  output logic [MAX_TAPS-1:0][SAMPLE_W-1:0]  job_win
);

  localparam int HIST_D = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;

  logic [HIST_D-1:0][SAMPLE_W-1:0]   hist_r, hist_nxt;
  logic [SEEN_W-1:0]                 seen_r, seen_nxt;
  logic                              job_valid_r, job_valid_nxt;
  logic                              job_single_r, job_single_nxt;
  logic                              job_end_r, job_end_nxt;
  logic                              job_bad_r, job_bad_nxt;
  logic [D_W-1:0]                    job_d_r, job_d_nxt;
  logic [D_W-1:0]                    job_half_r, job_half_nxt;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] job_win_r, job_win_nxt;

  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win_in, win_sh, win_step;
  logic                              kernel_bad;
  logic [D_W-1:0]                    half;
  logic [D_W-1:0]                    d0;
  logic                              p_ge_half;
  logic                              job_final;
  logic                              in_accept;
  logic                              load;

  always_comb begin
    kernel_bad = !cfg.tap_count[0] || (int'(cfg.tap_count) > MAX_TAPS);
    half       = D_W'(cfg.tap_count >> 1);
    p_ge_half  = seen_r >= SEEN_W'(half);

    win_in[0] = in_data.sample;
    for (int i = 1; i < MAX_TAPS; i++) begin
      win_in[i] = hist_r[i-1];
    end

    // zeros stand in for samples past the scan end
    if (p_ge_half || !in_data.scan_end || kernel_bad) begin
      d0 = '0;
    end else begin
      d0 = half - seen_r[D_W-1:0];
    end

    win_sh = win_in;
    for (int s = 0; s < HALF_MAX; s++) begin
      if (D_W'(s) < d0) begin
        for (int i = MAX_TAPS - 1; i > 0; i--) begin
          win_sh[i] = win_sh[i-1];
        end
        win_sh[0] = '0;
      end
    end

    for (int i = MAX_TAPS - 1; i > 0; i--) begin
      win_step[i] = job_win_r[i-1];
    end
    win_step[0] = '0;

    job_final = job_single_r || (job_d_r == job_half_r);
    in_stall  = job_valid_r && !(job_adv && job_final);
    in_accept = in_valid && !in_stall;
    load      = in_accept && (kernel_bad || in_data.scan_end || p_ge_half);

    job_valid_nxt  = job_valid_r;
    job_single_nxt = job_single_r;
    job_end_nxt    = job_end_r;
    job_bad_nxt    = job_bad_r;
    job_d_nxt      = job_d_r;
    job_half_nxt   = job_half_r;
    job_win_nxt    = job_win_r;

    if (job_valid_r && job_adv) begin
      if (job_final) begin
        job_valid_nxt = 1'b0;
      end else begin
        job_d_nxt   = job_d_r + 1'b1;
        job_win_nxt = win_step;
      end
    end

    if (load) begin
      job_valid_nxt  = 1'b1;
      job_single_nxt = kernel_bad || !in_data.scan_end;
      job_end_nxt    = in_data.scan_end;
      job_bad_nxt    = kernel_bad;
      job_d_nxt      = d0;
      job_half_nxt   = half;
      job_win_nxt    = win_sh;
    end

    hist_nxt = hist_r;
    seen_nxt = seen_r;
    if (in_accept) begin
      if (in_data.scan_end) begin
        hist_nxt = '0;
        seen_nxt = '0;
      end else begin
        for (int i = 0; i < HIST_D; i++) begin
          hist_nxt[i] = win_in[i];
        end
        if (seen_r < SEEN_W'(SEEN_MAX)) begin
          seen_nxt = seen_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r      <= '0;
      seen_r      <= '0;
      job_valid_r <= 1'b0;
    end else begin
      hist_r      <= hist_nxt;
      seen_r      <= seen_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_single_r <= job_single_nxt;
    job_end_r    <= job_end_nxt;
    job_bad_r    <= job_bad_nxt;
    job_d_r      <= job_d_nxt;
    job_half_r   <= job_half_nxt;
    job_win_r    <= job_win_nxt;
  end

  assign job_valid          = job_valid_r;
  assign job_ctl.run_last   = job_end_r && job_final;
  assign job_ctl.bad_kernel = job_bad_r;
  assign job_win            = job_win_r;

endmodule

>>> src/fsmc_mac.sv
// ----------------------------------------------------------------------------
// fsmc_mac
// tap products, sum, rounding and saturation, output register
// ----------------------------------------------------------------------------
module fsmc_mac import fsmc_pkg::*; #(
  parameter int MAX_TAPS       = 7,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cfg_t                               cfg,
  input  logic                               job_valid,
  input  job_ctl_t                           job_ctl,
  input  logic [MAX_TAPS-1:0][SAMPLE_W-1:0]  job_win,
  output logic                               job_adv,
  output logic                               out_valid,
  output out_word_t                          out_data,
  input  logic                               out_stall
);

  localparam int SUM_W = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int RND_W = SUM_W + 1;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'(VAL_MAX);
  localparam logic signed [RND_W-1:0] SAT_LO   = RND_W'(VAL_MIN);

  logic [MAX_TAPS-1:0][COEF_W-1:0] coef_sel;
  logic signed [PROD_W-1:0]        prod_nxt [MAX_TAPS];
  logic signed [PROD_W-1:0]        prod_r   [MAX_TAPS];
  logic                            s1_valid_r;
  job_ctl_t                        s1_ctl_r;
  logic signed [SUM_W-1:0]         sum_nxt, sum_r;
  logic                            s2_valid_r;
  job_ctl_t                        s2_ctl_r;
  logic signed [RND_W-1:0]         rnd, shifted;
  logic signed [SAMPLE_W-1:0]      sat;
  logic                            out_valid_r;
  out_word_t                       out_data_r, out_data_nxt;
  logic                            out_adv, s2_adv, s1_adv;

  // taps at or above the tap count drop out
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
    if (j < NUM_COEF) begin : g_live
      assign coef_sel[j] = (int'(cfg.tap_count) > j) ? cfg.coef[j] : '0;
    end else begin : g_none
      assign coef_sel[j] = '0;
    end
  end

  assign out_adv = !out_valid_r || !out_stall;
  assign s2_adv  = !s2_valid_r || out_adv;
  assign s1_adv  = !s1_valid_r || s2_adv;
  assign job_adv = s1_adv;

  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      prod_nxt[j] = $signed(coef_sel[j]) * $signed(job_win[j]);
    end

    sum_nxt = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      sum_nxt = sum_nxt + {{(SUM_W-PROD_W){prod_r[j][PROD_W-1]}}, prod_r[j]};
    end

    // round half up, then clamp to the sample range
    rnd     = {sum_r[SUM_W-1], sum_r} + RND_HALF;
    shifted = rnd >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      sat = SAT_HI[SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end

    out_data_nxt.filtered   = s2_ctl_r.bad_kernel ? '0 : sat;
    out_data_nxt.run_last   = s2_ctl_r.run_last;
    out_data_nxt.bad_kernel = s2_ctl_r.bad_kernel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= job_valid;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prod_r   <= prod_nxt;
      s1_ctl_r <= job_ctl;
    end
    if (s2_adv) begin
      sum_r    <= sum_nxt;
      s2_ctl_r <= s1_ctl_r;
    end
    if (out_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/fir_same_mode_convolution.sv
// ----------------------------------------------------------------------------
// fir_same_mode_convolution
// same-length fir convolution of a scan of samples with an odd kernel
// ----------------------------------------------------------------------------
// One sample word is taken per cycle while in_stall is low. A scan of n
// samples gives n result words: result p appears once sample
// p + (tap_count-1)/2 has arrived, and the word that carries scan_end
// releases the last results of the scan, up to (tap_count-1)/2 + 1 words,
// one per cycle while out_stall is low; the sequencer in the window stage
// stalls the input while they are released. A result word passes through
// the window register, tap product register, sum register and output
// register. Samples outside the scan count as zero; scan_end clears the
// history. The value is the coefficient-weighted sum shifted right by
// COEF_FRAC_BITS, rounded half up and saturated to 24 bits. An even tap
// count gives one word per input with bad_kernel set and filtered zero.
// The user must write registers only while the block is idle; the block
// itself does not enforce this.
module fir_same_mode_convolution import fsmc_pkg::*; #(
  parameter int MAX_TAPS       = 7,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample words
  input  logic                  in_valid,
  input  in_word_t              in_data,
  output logic                  in_stall,
  // result words
  output logic                  out_valid,
  output out_word_t             out_data,
  input  logic                  out_stall,
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                              cfg;
  logic                              job_valid;
  logic                              job_adv;
  job_ctl_t                          job_ctl;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] job_win;

  // tap count and coefficients
  fsmc_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // history, scan position and per-result window
  fsmc_window #(
    .MAX_TAPS (MAX_TAPS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .job_adv   (job_adv),
    .job_valid (job_valid),
    .job_ctl   (job_ctl),
    .job_win   (job_win)
  );

  // multiply, accumulate, round and saturate
  fsmc_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ctl   (job_ctl),
    .job_win   (job_win),
    .job_adv   (job_adv),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

>>> bench/tb_fir_same_mode_convolution.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fir_same_mode_convolution
// self-checking bench for the same-length fir convolution block
// ----------------------------------------------------------------------------
// Sample words are queued by the stimulus process and handed to the block by
// a clocked driver. Every accepted word runs through a local fir model that
// predicts the result words it releases. A clocked monitor pops the oldest
// prediction for each result word taken and compares all fields. Kernels are
// loaded over the register port only while the block is drained. A short
// directed run covers the field extremes, rounding, saturation, short scans,
// even tap counts and a kernel swap inside an open scan; random kernels and
// scans follow.
// ----------------------------------------------------------------------------
module tb_fir_same_mode_convolution;
  import fsmc_pkg::*;

  localparam int COEF_FRAC_BITS = 16;
  localparam int FIR_TAPS       = 7;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int DRAIN_CYCLES   = 8;      // four pipeline stages plus margin
  localparam int HOLD_CYCLES    = 150;    // long receiver hold-off

  typedef enum int {FILL_MAX, FILL_MIN, FILL_HALF, FILL_RANDOM} coef_fill_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  in_word_t              in_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  out_stall = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // sample words waiting for the driver, result words still owed by the block
  in_word_t  scan_words[$];
  out_word_t pending_results[$];

  // fir model state: kernel registers, sample history (newest first), position
  logic [TAP_CNT_W-1:0]     kernel_taps = TAP_COUNT_RESET;
  logic signed [COEF_W-1:0] kernel_coef [NUM_COEF] = '{COEF_0_RESET, 0, 0, 0, 0, 0, 0};
  longint                   past_samples [FIR_TAPS-1] = '{default: 0};
  int                       scan_pos = 0;

  int errors = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  fir_same_mode_convolution #(
    .MAX_TAPS      (FIR_TAPS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // weighted sum of the window for output y[p-d], rounded half up, clipped
  function automatic logic [SAMPLE_W-1:0] tap_sum(input longint win [FIR_TAPS],
                                                  input int taps, input int d);
    longint acc = 0;
    for (int j = d; j < taps; j++)
      acc += longint'(kernel_coef[j]) * win[j - d];
    acc = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (acc > VAL_MAX) acc = VAL_MAX;
    else if (acc < VAL_MIN) acc = VAL_MIN;
    return acc[SAMPLE_W-1:0];
  endfunction

  // append one predicted result word
  function automatic void add_result(input out_word_t w);
    pending_results.insert(pending_results.size(), w);
  endfunction

  // results released by one accepted sample word, then the history update
  function automatic void fir_predict(input in_word_t word);
    longint win [FIR_TAPS];
    int     taps;
    int     half;
    int     d;
    taps = int'(kernel_taps);
    win[0] = longint'($signed(word.sample));
    for (int i = 1; i < FIR_TAPS; i++) win[i] = past_samples[i - 1];
    if (!kernel_taps[0] || taps > FIR_TAPS) begin
      // even tap count: error word per sample, value zero
      add_result(out_word_t'{filtered: '0, run_last: word.scan_end, bad_kernel: 1'b1});
    end else begin
      half = (taps - 1) / 2;
      if (!word.scan_end) begin
        if (scan_pos >= half)
          add_result(out_word_t'{filtered: tap_sum(win, taps, 0),
                                 run_last: 1'b0, bad_kernel: 1'b0});
      end else begin
        // scan end flushes the delayed outputs, all of them for a short scan
        for (d = (scan_pos >= half) ? 0 : half - scan_pos; d <= half; d++)
          add_result(out_word_t'{filtered: tap_sum(win, taps, d),
                                 run_last: (d == half), bad_kernel: 1'b0});
      end
    end
    if (word.scan_end) begin
      for (int i = 0; i < FIR_TAPS - 1; i++) past_samples[i] = 0;
      scan_pos = 0;
    end else begin
      for (int i = FIR_TAPS - 2; i > 0; i--) past_samples[i] = past_samples[i - 1];
      past_samples[0] = win[0];
      if (scan_pos < SEEN_MAX) scan_pos++;
    end
  endfunction

  function automatic void push_word(input logic [SAMPLE_W-1:0] s, input logic last);
    scan_words.insert(scan_words.size(), in_word_t'{sample: s, scan_end: last});
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(4))
      0: case ($urandom_range(3))
           0: return 24'h7FFFFF;
           1: return 24'h800000;
           2: return 24'h000000;
           default: return 24'hFFFFFF;
         endcase
      1: return SAMPLE_W'(int'($urandom_range(2047)) - 1024);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(3))
      0: case ($urandom_range(3))
           0: return 18'h1FFFF;
           1: return 18'h20000;
           2: return 18'h00000;
           default: return 18'h10000;    // unity
         endcase
      1: return COEF_W'(int'($urandom_range(8191)) - 4096);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // register write in setup and access phases, model follows at the write edge
  task automatic write_reg(input int idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_ADDR_W'(4 * idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == int'(REG_TAP_COUNT)) kernel_taps = value[TAP_CNT_W-1:0];
    else kernel_coef[idx - int'(REG_COEF_BASE)] = value[COEF_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // upper data bits carry noise, the block must ignore them
  task automatic load_kernel(input int taps, input coef_fill_e fill);
    logic [APB_DATA_W-1:0] value;
    logic [COEF_W-1:0]     c;
    value = $urandom;
    value[TAP_CNT_W-1:0] = TAP_CNT_W'(taps);
    write_reg(int'(REG_TAP_COUNT), value);
    for (int i = 0; i < NUM_COEF; i++) begin
      case (fill)
        FILL_MAX:  c = 18'h1FFFF;
        FILL_MIN:  c = 18'h20000;
        FILL_HALF: c = (i == 0) ? 18'd32768 : 18'd0;
        default:   c = pick_coef();
      endcase
      value = $urandom;
      value[COEF_W-1:0] = c;
      write_reg(int'(REG_COEF_BASE) + i, value);
    end
  endtask

  // wait until every word is taken and every result has come back
  task automatic drain_block();
    do @(negedge clk);
    while (scan_words.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    int taps;
    int budget;
    int len;
    bit open_scan;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset kernel is a single unit tap: words pass through unchanged
    push_word(24'h7FFFFF, 1'b0);
    push_word(24'h800000, 1'b0);
    push_word(24'h000000, 1'b0);
    push_word(24'hFFFFFF, 1'b0);
    push_word(24'h000001, 1'b1);
    push_word(24'h123456, 1'b1);           // one-word scan
    drain_block();

    // half-unit tap: odd samples land exactly on the rounding midpoint
    load_kernel(1, FILL_HALF);
    push_word(24'h000001, 1'b0);
    push_word(24'hFFFFFF, 1'b0);
    push_word(24'h000003, 1'b0);
    push_word(24'hFFFFFD, 1'b1);
    drain_block();

    // widest kernel at full scale: positive and negative saturation,
    // both scans shorter than half the kernel
    load_kernel(7, FILL_MAX);
    push_word(24'h7FFFFF, 1'b0);
    push_word(24'h7FFFFF, 1'b1);
    push_word(24'h800000, 1'b0);
    push_word(24'h800000, 1'b0);
    push_word(24'h800000, 1'b1);
    drain_block();
    load_kernel(7, FILL_MIN);
    push_word(24'h800000, 1'b1);
    drain_block();

    // even tap counts give error words, zero included
    load_kernel(4, FILL_RANDOM);
    push_word(pick_sample(), 1'b0);
    push_word(pick_sample(), 1'b0);
    push_word(pick_sample(), 1'b1);
    drain_block();
    load_kernel(0, FILL_RANDOM);
    push_word(pick_sample(), 1'b1);
    drain_block();

    // kernel swapped while a scan is still open
    load_kernel(5, FILL_RANDOM);
    push_word(pick_sample(), 1'b0);
    push_word(pick_sample(), 1'b0);
    push_word(pick_sample(), 1'b0);
    drain_block();
    load_kernel(3, FILL_RANDOM);
    push_word(pick_sample(), 1'b0);
    push_word(pick_sample(), 1'b1);
    drain_block();

    // random kernels, mostly odd, each with a batch of scans
    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(9) < 8) taps = 2 * $urandom_range(3) + 1;
      else taps = 2 * $urandom_range(3);
      load_kernel(taps, FILL_RANDOM);
      budget = 31;
      while (budget > 0) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(9, 1);
        if (len > budget) len = budget;
        budget -= len;
        // sometimes the scan stays open into the next kernel
        open_scan = (budget == 0) && ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++)
          push_word(pick_sample(), (i == len - 1) && !open_scan);
      end
      drain_block();
    end

    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver
  // a word stays on the bus until taken; idling is off for a stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fir_predict(in_data);
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (scan_words.size() != 0 &&
            !((words_accepted < 120 || words_accepted >= 200) &&
              $urandom_range(99) < 13)) begin
          in_valid <= 1'b1;
          in_data  <= scan_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word: filtered=%0d last=%b bad=%b", $time,
                   out_data.filtered, out_data.run_last, out_data.bad_kernel);
          errors++;
        end else begin
          if (out_data.filtered !== pending_results[0].filtered ||
              out_data.run_last !== pending_results[0].run_last ||
              out_data.bad_kernel !== pending_results[0].bad_kernel) begin
            $display("%0t: result mismatch: expected filtered=%0d last=%b bad=%b, got filtered=%0d last=%b bad=%b",
                     $time, pending_results[0].filtered, pending_results[0].run_last,
                     pending_results[0].bad_kernel, out_data.filtered, out_data.run_last,
                     out_data.bad_kernel);
            errors++;
          end
          void'(pending_results.pop_front());
        end
        results_checked++;
      end
      // one long hold-off lets the block back up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_checked >= 80) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (results_checked < 120 || results_checked >= 200) &&
                     ($urandom_range(99) < 13);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
